>>> rtl/core/bpt_pkg.sv
// ----------------------------------------------------------------------------
// bpt_pkg
// shared types and constants of the breakpoint table
// ----------------------------------------------------------------------------
package bpt_pkg;

  typedef enum logic [1:0] {
    ACT_SET    = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  localparam logic [2:0] KIND_PLAIN  = 3'd1;
  localparam logic [2:0] KIND_RETURN = 3'd2;
  localparam logic [2:0] KIND_STEP   = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] address;
    logic [2:0]  flags;
    logic [31:0] frame_value;
    logic        readable;
    logic [3:0]  read_slot;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  entry_slot;
    logic [2:0]  entry_flags;
    logic [31:0] entry_address;
    logic [31:0] return_frame;
    logic [31:0] step_frame;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] addr;
    logic [31:0] ret;
    logic [31:0] stp;
  } entry_t;

endpackage

>>> rtl/core/bpt_in_if.sv
// ----------------------------------------------------------------------------
// bpt_in_if
// request channel of the breakpoint table
// ----------------------------------------------------------------------------
interface bpt_in_if;
  logic               valid;
  logic               ready;
  bpt_pkg::in_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/bpt_out_if.sv
// ----------------------------------------------------------------------------
// bpt_out_if
// response channel of the breakpoint table
// ----------------------------------------------------------------------------
interface bpt_out_if;
  logic                valid;
  logic                ready;
  bpt_pkg::out_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/bpt_ram.sv
// ----------------------------------------------------------------------------
// bpt_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/core/breakpoint_table_core.sv
// ----------------------------------------------------------------------------
// breakpoint_table_core
// breakpoint table: set, delete, clear all and read of breakpoint entries
// ----------------------------------------------------------------------------
// Entries live in one ram with a registered read; a per-entry valid flop marks
// entries whose kind field is live, so clear all takes effect at once. Set and
// delete walk the ram one entry at a time (read state, then check state) and
// present their result word after the walk ends, which is early when a delete
// or a set at a live address hits. A read passes through the read and check
// states; clear all, a set that is unreadable or of kind 0 and a read of a
// slot beyond the table go straight to the done state. One request is in
// work at a time; a finished word waits in the output register while the
// next request is accepted, and a request that finishes while that register
// is still held stalls until it drains.
module breakpoint_table_core #(
  parameter int ENTRIES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpt_in_if.sink     in_i,
  bpt_out_if.source  out_o
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_WR,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic [1:0]           op_q;
  logic [31:0]          req_addr_q;
  logic [2:0]           req_flags_q;
  logic [31:0]          req_frame_q;
  logic [IW-1:0]        idx_q;
  logic                 free_found_q;
  logic [IW-1:0]        sel_slot_q;
  bpt_pkg::entry_t      sel_q;
  logic [ENTRIES-1:0]   valid_q;
  bpt_pkg::out_word_t   res_q;
  logic                 out_vld_q;
  bpt_pkg::out_word_t   out_word_q;

  logic                 ram_we;
  logic                 ram_re;
  bpt_pkg::entry_t      ram_wdata;
  logic [$bits(bpt_pkg::entry_t)-1:0] ram_rdata_raw;
  bpt_pkg::entry_t      ram_rdata;
  bpt_pkg::entry_t      rd_entry;
  bpt_pkg::out_word_t   res_init;

  logic [2:0]           cur_kind;
  logic                 live_hit;
  logic                 is_free;
  logic                 del_hit;
  logic                 set_fail;
  logic [31:0]          rslot_w;
  logic [31:0]          idx_w;
  logic [31:0]          sel_w;
  logic                 out_free;

  bpt_ram #(
    .WIDTH ($bits(bpt_pkg::entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (sel_slot_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = bpt_pkg::entry_t'(ram_rdata_raw);
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_o.valid = out_vld_q;
  assign out_o.data = out_word_q;
  assign out_free = !out_vld_q || out_o.ready;
  assign rslot_w = 32'(in_i.data.read_slot);
  assign idx_w = 32'(idx_q);
  assign sel_w = 32'(sel_slot_q);

  always_comb begin
    cur_kind = valid_q[idx_q] ? ram_rdata.kind : 3'd0;
    rd_entry = ram_rdata;
    rd_entry.kind = cur_kind;
    res_init = '0;
    res_init.ok = (in_i.data.action == bpt_pkg::ACT_CLEAR);
    live_hit = (cur_kind != 3'd0) && (ram_rdata.addr == req_addr_q);
    is_free  = (cur_kind == 3'd0);
    del_hit  = ((cur_kind & req_flags_q) != 3'd0) && (ram_rdata.addr == req_addr_q);
    set_fail = (req_flags_q != bpt_pkg::KIND_PLAIN) &&
               ((sel_q.kind & req_flags_q) != 3'd0);
    ram_re = (state_q == ST_RD);
    ram_wdata = sel_q;
    ram_we = 1'b0;
    if (state_q == ST_WR) begin
      if (op_q == bpt_pkg::ACT_SET) begin
        ram_we = !set_fail;
        ram_wdata.kind = sel_q.kind | req_flags_q;
        ram_wdata.addr = req_addr_q;
        if (req_flags_q == bpt_pkg::KIND_RETURN) begin
          ram_wdata.ret = req_frame_q;
        end
        if (req_flags_q == bpt_pkg::KIND_STEP) begin
          ram_wdata.stp = req_frame_q;
        end
      end else begin
        ram_we = 1'b1;
        ram_wdata.kind = sel_q.kind & ~req_flags_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      out_vld_q    <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      if (out_vld_q && out_o.ready && state_q != ST_DONE) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            op_q         <= in_i.data.action;
            req_addr_q   <= in_i.data.address;
            req_flags_q  <= in_i.data.flags;
            req_frame_q  <= in_i.data.frame_value;
            free_found_q <= 1'b0;
            idx_q        <= '0;
            res_q        <= res_init;
            case (bpt_pkg::action_e'(in_i.data.action))
              bpt_pkg::ACT_SET: begin
                if (in_i.data.readable && in_i.data.flags != 3'd0) begin
                  state_q <= ST_RD;
                end else begin
                  state_q <= ST_DONE;
                end
              end
              bpt_pkg::ACT_DELETE: begin
                state_q <= ST_RD;
              end
              bpt_pkg::ACT_CLEAR: begin
                valid_q  <= '0;
                state_q  <= ST_DONE;
              end
              default: begin
                if (rslot_w < 32'(ENTRIES)) begin
                  idx_q   <= rslot_w[IW-1:0];
                  state_q <= ST_RD;
                end else begin
                  state_q <= ST_DONE;
                end
              end
            endcase
          end
        end
        ST_RD: begin
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          case (bpt_pkg::action_e'(op_q))
            bpt_pkg::ACT_SET: begin
              if (live_hit) begin
                sel_slot_q <= idx_q;
                sel_q      <= rd_entry;
                state_q    <= ST_WR;
              end else begin
                if (is_free && !free_found_q) begin
                  free_found_q <= 1'b1;
                  sel_slot_q   <= idx_q;
                  sel_q        <= rd_entry;
                end
                if (idx_q == LAST) begin
                  state_q <= (free_found_q || is_free) ? ST_WR : ST_DONE;
                end else begin
                  idx_q   <= idx_q + 1'b1;
                  state_q <= ST_RD;
                end
              end
            end
            bpt_pkg::ACT_DELETE: begin
              if (del_hit) begin
                sel_slot_q <= idx_q;
                sel_q      <= rd_entry;
                state_q    <= ST_WR;
              end else if (idx_q == LAST) begin
                state_q <= ST_DONE;
              end else begin
                idx_q   <= idx_q + 1'b1;
                state_q <= ST_RD;
              end
            end
            default: begin
              res_q   <= {1'b1, idx_w[3:0], cur_kind, ram_rdata.addr, ram_rdata.ret,
                          ram_rdata.stp};
              state_q <= ST_DONE;
            end
          endcase
        end
        ST_WR: begin
          if (ram_we) begin
            valid_q[sel_slot_q] <= 1'b1;
            res_q <= {1'b1, sel_w[3:0], ram_wdata.kind, ram_wdata.addr, ram_wdata.ret,
                      ram_wdata.stp};
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_word_q <= res_q;
            out_vld_q  <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
